[rtl/core/rrss_pkg.sv]
// Shared constants and types for the round-robin sleep scheduler.
package rrss_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [2:0] KIND_CREATE  = 3'd0;
  localparam logic [2:0] KIND_SLEEP   = 3'd1;
  localparam logic [2:0] KIND_EXIT    = 3'd2;
  localparam logic [2:0] KIND_PREEMPT = 3'd3;
  localparam logic [2:0] KIND_TICK    = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NO_READY = 2'd2;
  localparam logic [1:0] STATUS_NO_RUN   = 2'd3;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

[rtl/core/rrss_cell.sv]
// One cell of the sorted sleep row: holds one sleeper and trades it with its neighbors.
module rrss_cell import rrss_pkg::*; #(
  parameter int PW = 4,
  parameter int TW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctl_t     ctl,
  input  logic [PW-1:0] new_pid,
  input  logic [TW-1:0] new_time,
  input  logic          prev_valid,
  input  logic          prev_after,
  input  logic [PW-1:0] prev_pid,
  input  logic [TW-1:0] prev_time,
  input  logic          next_valid,
  input  logic [PW-1:0] next_pid,
  input  logic [TW-1:0] next_time,
  output logic          valid,
  output logic          after,
  output logic [PW-1:0] pid,
  output logic [TW-1:0] wt
);

  assign after = valid && (wt <= new_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins && !after) begin
      if (prev_after) begin
        valid <= 1'b1;
        pid   <= new_pid;
        wt    <= new_time;
      end else begin
        valid <= prev_valid;
        pid   <= prev_pid;
        wt    <= prev_time;
      end
    end else if (ctl.pop) begin
      valid <= next_valid;
      pid   <= next_pid;
      wt    <= next_time;
    end
  end

endmodule

[rtl/core/rrss_sleep_chain.sv]
// Row of sleep cells kept in wake-time order, with sorted insertion and pop at the head.
module rrss_sleep_chain import rrss_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int PW = 4,
  parameter int TW = TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctl_t     ctl,
  input  logic [PW-1:0] new_pid,
  input  logic [TW-1:0] new_time,
  output logic          head_valid,
  output logic [PW-1:0] head_pid,
  output logic [TW-1:0] head_time
);

  logic          v     [MAX_TASKS];
  logic          aft   [MAX_TASKS];
  logic [PW-1:0] p     [MAX_TASKS];
  logic [TW-1:0] t     [MAX_TASKS];
  cell_ctl_t     gated;

  assign gated.ins = ctl.ins && !v[MAX_TASKS-1];
  assign gated.pop = ctl.pop;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic          pv, pa, nv;
    logic [PW-1:0] pp, np;
    logic [TW-1:0] pt, nt;
    if (i == 0) begin : g_first
      assign pv = 1'b1;
      assign pa = 1'b1;
      assign pp = new_pid;
      assign pt = new_time;
    end else begin : g_mid
      assign pv = v[i-1];
      assign pa = aft[i-1];
      assign pp = p[i-1];
      assign pt = t[i-1];
    end
    if (i == MAX_TASKS - 1) begin : g_last
      assign nv = 1'b0;
      assign np = '0;
      assign nt = '0;
    end else begin : g_inner
      assign nv = v[i+1];
      assign np = p[i+1];
      assign nt = t[i+1];
    end
    rrss_cell #(.PW(PW), .TW(TW)) u_cell (
      .clk(clk), .rst(rst), .ctl(gated), .new_pid(new_pid), .new_time(new_time),
      .prev_valid(pv), .prev_after(pa), .prev_pid(pp), .prev_time(pt),
      .next_valid(nv), .next_pid(np), .next_time(nt),
      .valid(v[i]), .after(aft[i]), .pid(p[i]), .wt(t[i])
    );
  end

  assign head_valid = v[0];
  assign head_pid   = p[0];
  assign head_time  = t[0];

endmodule

[rtl/core/round_robin_sleep_scheduler.sv]
// Top level of the round-robin task scheduler with a timed sleep queue.
// One item is taken at a time. Create, tick, unknown kinds and rejected sleep, exit or
// preempt items go from acceptance straight to the finish state, which registers their
// result. Accepted sleep, exit and preempt items first pass a wake state and a switch
// state before the finish state; the wake walk pops one sleeper per cycle from the head
// of the sorted cell row while its head is due. A sleep insertion into that row finishes
// in the accept cycle. The result sits in an output register, so the next item is accepted
// while it waits to be taken, but that item cannot finish until the waiting result has left.
module round_robin_sleep_scheduler import rrss_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] sleep_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  running_pid,
  output logic        running_valid,
  output logic        switched,
  output logic [3:0]  previous_pid,
  output logic [3:0]  created_pid,
  output logic [4:0]  woken_count,
  output logic [1:0]  status
);

  localparam int PW = $clog2(MAX_TASKS);
  localparam int TW = TIME_BITS;
  localparam logic [PW:0] MAXV = (PW+1)'(MAX_TASKS);

  typedef enum logic [1:0] {S_IDLE, S_WAKE, S_SWITCH, S_FIN} state_t;

  state_t        state;
  logic [PW-1:0] cur_pid;
  logic          cur_valid, cur_run;
  logic [PW:0]   nfp;
  logic [TW-1:0] secs_now;
  logic [PW-1:0] rhead;
  logic [PW:0]   rcount;
  logic [PW-1:0] ring [MAX_TASKS];
  logic [PW-1:0] head_data;

  logic          ev_switched;
  logic [PW-1:0] ev_prev, ev_created;
  logic [PW:0]   ev_woken;
  logic [1:0]    ev_status;

  logic          ring_we;
  logic [PW-1:0] ring_wdata, tail, hnext;
  logic [PW:0]   tail_sum, head_sum;
  cell_ctl_t     ctl;
  logic          head_valid, due, room;
  logic [PW-1:0] head_pid;
  logic [TW-1:0] head_time, wake;
  logic [TW+15:0] secs_ext;
  logic [PW+3:0] cur_ext, prev_ext, created_ext;
  logic [PW+5:0] woken_ext;

  assign in_ready = (state == S_IDLE);
  assign secs_ext = {{TW{1'b0}}, sleep_seconds};
  assign wake     = secs_now + secs_ext[TW-1:0];
  assign due      = head_valid && (secs_now >= head_time);
  assign room     = (rcount < MAXV);
  assign tail_sum = {1'b0, rhead} + rcount;
  assign tail     = (tail_sum >= MAXV) ? PW'(tail_sum - MAXV) : tail_sum[PW-1:0];
  assign head_sum = {1'b0, rhead} + (PW+1)'(1);
  assign hnext    = (head_sum >= MAXV) ? PW'(head_sum - MAXV) : head_sum[PW-1:0];

  assign cur_ext     = {4'b0, cur_pid};
  assign prev_ext    = {4'b0, ev_prev};
  assign created_ext = {4'b0, ev_created};
  assign woken_ext   = {5'b0, ev_woken};

  always_comb begin
    ring_we    = 1'b0;
    ring_wdata = cur_pid;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_CREATE && nfp < MAXV && cur_valid && room) begin
            ring_we    = 1'b1;
            ring_wdata = nfp[PW-1:0];
          end
          if (kind == KIND_SLEEP && cur_valid && cur_run) begin
            ctl.ins = 1'b1;
          end
        end
      end
      S_WAKE: begin
        if (due) begin
          ctl.pop    = 1'b1;
          ring_we    = room;
          ring_wdata = head_pid;
        end
      end
      S_SWITCH: begin
        ring_we = (rcount != '0) && cur_run && room;
      end
      default: begin
      end
    endcase
  end

  rrss_sleep_chain #(.MAX_TASKS(MAX_TASKS), .PW(PW), .TW(TW)) u_chain (
    .clk(clk), .rst(rst), .ctl(ctl), .new_pid(cur_pid), .new_time(wake),
    .head_valid(head_valid), .head_pid(head_pid), .head_time(head_time)
  );

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[tail] <= ring_wdata;
    end
    head_data <= ring[rhead];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_pid   <= '0;
      cur_valid <= 1'b0;
      cur_run   <= 1'b0;
      nfp       <= '0;
      secs_now  <= '0;
      rhead     <= '0;
      rcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ev_switched <= 1'b0;
            ev_prev     <= '0;
            ev_woken    <= '0;
            case (kind)
              KIND_CREATE: begin
                state <= S_FIN;
                if (nfp >= MAXV) begin
                  ev_status  <= STATUS_FULL;
                  ev_created <= '0;
                end else begin
                  ev_status  <= STATUS_OK;
                  ev_created <= nfp[PW-1:0];
                  nfp        <= nfp + (PW+1)'(1);
                  if (!cur_valid) begin
                    cur_pid   <= nfp[PW-1:0];
                    cur_valid <= 1'b1;
                    cur_run   <= 1'b1;
                  end else if (room) begin
                    rcount <= rcount + (PW+1)'(1);
                  end
                end
              end
              KIND_SLEEP, KIND_EXIT: begin
                ev_created <= '0;
                if (!(cur_valid && cur_run)) begin
                  ev_status <= STATUS_NO_RUN;
                  state     <= S_FIN;
                end else begin
                  ev_status <= STATUS_OK;
                  cur_run   <= 1'b0;
                  state     <= S_WAKE;
                end
              end
              KIND_PREEMPT: begin
                ev_created <= '0;
                if (!cur_valid) begin
                  ev_status <= STATUS_NO_RUN;
                  state     <= S_FIN;
                end else begin
                  ev_status <= STATUS_OK;
                  state     <= S_WAKE;
                end
              end
              KIND_TICK: begin
                ev_created <= '0;
                ev_status  <= STATUS_OK;
                state      <= S_FIN;
                secs_now   <= secs_now + TW'(1);
              end
              default: begin
                ev_created <= '0;
                ev_status  <= STATUS_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_WAKE: begin
          if (due) begin
            ev_woken <= ev_woken + (PW+1)'(1);
            if (room) begin
              rcount <= rcount + (PW+1)'(1);
            end
          end else begin
            state <= S_SWITCH;
          end
        end
        S_SWITCH: begin
          if (rcount == '0) begin
            ev_status <= STATUS_NO_READY;
          end else begin
            ev_prev     <= cur_pid;
            ev_switched <= 1'b1;
            cur_pid     <= head_data;
            cur_run     <= 1'b1;
            rhead       <= hnext;
            rcount      <= rcount + (PW+1)'(cur_run && room) - (PW+1)'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            running_pid   <= cur_ext[3:0];
            running_valid <= cur_valid && cur_run;
            switched      <= ev_switched;
            previous_pid  <= prev_ext[3:0];
            created_pid   <= created_ext[3:0];
            woken_count   <= woken_ext[4:0];
            status        <= ev_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/rrss_checker.sv]
// Port-level checks for the round-robin sleep scheduler, bound to the top level.
module rrss_checker import rrss_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] running_pid,
  input logic       running_valid,
  input logic       switched,
  input logic [4:0] woken_count,
  input logic [1:0] status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_pid) && $stable(status))
    else $error("Result item changed while stalled.");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && switched |-> status == STATUS_OK && running_valid)
    else $error("Switch reported without a running task.");

  a_no_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_NO_RUN |-> !switched && woken_count == 5'd0)
    else $error("Rejected event still switched or woke tasks.");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> !switched)
    else $error("Full-table create switched tasks.");

endmodule

bind round_robin_sleep_scheduler rrss_checker u_rrss_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .running_pid(running_pid), .running_valid(running_valid), .switched(switched),
  .woken_count(woken_count), .status(status)
);
